// ----- hw/rtl/rau_pkg.sv -----
// shared types and constants for the rational arithmetic unit
package rau_pkg;
   localparam int WordBits = 32;
   localparam int WideBits = 64;

   typedef enum logic [2:0] {
      MODE_ADD = 3'd0,
      MODE_SUB = 3'd1,
      MODE_MUL = 3'd2,
      MODE_DIV = 3'd3,
      MODE_CMP = 3'd4
   } mode_type;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_OVF  = 2'd1;
   localparam logic [1:0] ST_ZERO = 2'd2;

   localparam logic [1:0] ORD_LT = 2'd0;
   localparam logic [1:0] ORD_EQ = 2'd1;
   localparam logic [1:0] ORD_GT = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL1,
      S_MUL2,
      S_SUM,
      S_GCD_INIT,
      S_GCD_SH,
      S_GCD_A,
      S_GCD_LOOP,
      S_DIV_NUM,
      S_DIV_DEN,
      S_CHECK,
      S_DONE
   } state_type;

   // sequencer to datapath control
   typedef struct packed {
      logic load;
      logic mul1;
      logic mul2;
      logic sum;
      logic gcd_init;
      logic gcd_sh;
      logic gcd_a;
      logic gcd_loop;
      logic div_start_num;
      logic div_start_den;
      logic check;
   } ctrl_type;

   // datapath to sequencer status
   typedef struct packed {
      logic in_err;
      logic is_cmp;
      logic mag_zero;
      logic both_even;
      logic a_even;
      logic gcd_done;
      logic div_busy;
   } stat_type;
endpackage

// ----- hw/rtl/rau_divider.sv -----
// restoring divider, one quotient bit per cycle
module rau_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [rau_pkg::WideBits-1:0]   dividend,
   input  logic [rau_pkg::WideBits-1:0]   divisor,
   output logic                           busy,
   output logic [rau_pkg::WideBits-1:0]   quotient
);
   localparam int W = rau_pkg::WideBits;
   logic [W-1:0] q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic [W:0]   trial;
   logic [W-1:0] rs;

   assign busy = cnt_ff != 7'd0;
   assign quotient = q_ff;

   always_comb begin
      rs = {r_ff[W-2:0], q_ff[W-1]};
      trial = {1'b0, rs} - {1'b0, d_ff};
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      if (start) begin
         q_in = dividend;
         r_in = '0;
         d_in = divisor;
         cnt_in = 7'(W);
      end else if (busy) begin
         // remainder below divisor; r_ff[W-1] flags a carry out
         if (!trial[W] || r_ff[W-1]) begin
            r_in = rs - d_ff;
            q_in = {q_ff[W-2:0], 1'b1};
         end else begin
            r_in = rs;
            q_in = {q_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end
endmodule

// ----- hw/rtl/rau_datapath.sv -----
// operand registers, shared multiplier, gcd engine, divider and result check
module rau_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  rau_pkg::ctrl_type       ctrl,
   output rau_pkg::stat_type       stat,
   input  logic [2:0]              req_mode,
   input  logic signed [31:0]      req_a_num,
   input  logic [30:0]             req_a_den,
   input  logic signed [31:0]      req_b_num,
   input  logic [30:0]             req_b_den,
   output logic signed [31:0]      res_num,
   output logic [30:0]             res_den,
   output logic [1:0]              order,
   output logic [1:0]              status
);
   localparam int W = rau_pkg::WideBits;
   localparam int N = rau_pkg::WordBits;
   localparam logic [W-1:0] Lim = W'(1) << (N - 1);

   logic [2:0]  mode_ff;
   logic signed [32:0] an_ff, bn_ff;
   logic [30:0] ad_ff, bd_ff;
   logic signed [W-1:0] p1_ff, p2_ff;
   logic [W-1:0] mag_ff, den_ff, ga_ff, gb_ff, q_num_ff;
   logic neg_ff;
   logic [6:0] sh_ff;
   logic signed [31:0] num_ff;
   logic [30:0] dn_ff;
   logic [1:0] ord_ff, st_ff;

   // one shared signed multiplier, 33 by 33 bits
   logic signed [32:0] mx, my;
   logic signed [65:0] prod;
   logic is_arith_sub, is_mul, is_div;
   logic signed [W-1:0] sum;
   logic [W-1:0] gb_sub, gcd_val, div_dd, div_ds, div_q;
   logic div_busy;
   logic [W-1:0] mag_red, den_red;

   assign is_arith_sub = mode_ff == rau_pkg::MODE_SUB;
   assign is_mul = mode_ff == rau_pkg::MODE_MUL;
   assign is_div = mode_ff == rau_pkg::MODE_DIV;

   always_comb begin
      mx = an_ff;
      my = $signed({2'b0, bd_ff});
      if (ctrl.mul2) begin
         if (is_mul) begin
            mx = an_ff; my = bn_ff;
         end else if (is_div) begin
            mx = $signed({2'b0, ad_ff}); my = bn_ff;
         end else begin
            mx = is_arith_sub ? -bn_ff : bn_ff;
            my = $signed({2'b0, ad_ff});
         end
      end else if (ctrl.sum) begin
         mx = $signed({2'b0, ad_ff}); my = $signed({2'b0, bd_ff});
      end
      prod = mx * my;
   end

   assign sum = p1_ff + p2_ff;
   assign gb_sub = gb_ff - ga_ff;
   assign gcd_val = ga_ff << sh_ff[5:0];

   rau_divider u_div (
      .clock(clock), .reset(reset), .start(ctrl.div_start_num | ctrl.div_start_den),
      .dividend(div_dd), .divisor(div_ds), .busy(div_busy), .quotient(div_q));

   assign div_dd = ctrl.div_start_num ? mag_ff : den_ff;
   assign div_ds = gcd_val;
   assign mag_red = q_num_ff;
   assign den_red = div_q;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         mode_ff <= req_mode;
         an_ff <= 33'(req_a_num);
         bn_ff <= 33'(req_b_num);
         ad_ff <= req_a_den;
         bd_ff <= req_b_den;
         ord_ff <= rau_pkg::ORD_LT;
         num_ff <= '0;
         dn_ff <= 31'd1;
         st_ff <= rau_pkg::ST_OK;
         if (req_a_den == '0 || req_b_den == '0 ||
             (req_mode == rau_pkg::MODE_DIV && req_b_num == '0))
            st_ff <= rau_pkg::ST_ZERO;
      end
      if (ctrl.mul1) p1_ff <= W'(prod);
      if (ctrl.mul2) p2_ff <= W'(prod);
      if (ctrl.sum) begin
         den_ff <= W'(prod);
         if (mode_ff > rau_pkg::MODE_DIV) begin
            ord_ff <= (p1_ff < p2_ff) ? rau_pkg::ORD_LT :
                      (p1_ff == p2_ff) ? rau_pkg::ORD_EQ : rau_pkg::ORD_GT;
         end else if (is_mul) begin
            neg_ff <= p2_ff < 0;
            mag_ff <= p2_ff < 0 ? W'(-p2_ff) : p2_ff;
         end else if (is_div) begin
            // num = |an|*bd, den = ad*|bn|
            neg_ff <= (an_ff < 0) != (bn_ff < 0);
            mag_ff <= p1_ff < 0 ? W'(-p1_ff) : p1_ff;
            den_ff <= p2_ff < 0 ? W'(-p2_ff) : p2_ff;
         end else begin
            neg_ff <= sum < 0;
            mag_ff <= sum < 0 ? W'(-sum) : sum;
         end
      end
      if (ctrl.gcd_init) begin
         ga_ff <= mag_ff;
         gb_ff <= den_ff;
         sh_ff <= '0;
      end
      if (ctrl.gcd_sh) begin
         ga_ff <= ga_ff >> 1;
         gb_ff <= gb_ff >> 1;
         sh_ff <= sh_ff + 7'd1;
      end
      if (ctrl.gcd_a) ga_ff <= ga_ff >> 1;
      if (ctrl.gcd_loop) begin
         if (!gb_ff[0]) gb_ff <= gb_ff >> 1;
         else if (ga_ff > gb_ff) begin
            ga_ff <= gb_ff;
            gb_ff <= ga_ff - gb_ff;
         end else gb_ff <= gb_sub;
      end
      if (ctrl.div_start_den) q_num_ff <= div_q;
      if (ctrl.check) begin
         if (den_red > Lim - 1 || (neg_ff ? mag_red > Lim : mag_red > Lim - 1))
            st_ff <= rau_pkg::ST_OVF;
         else begin
            num_ff <= neg_ff ? 32'(-mag_red) : 32'(mag_red);
            dn_ff <= 31'(den_red);
         end
      end
   end

   assign stat.in_err = st_ff == rau_pkg::ST_ZERO;
   assign stat.is_cmp = mode_ff > rau_pkg::MODE_DIV;
   assign stat.mag_zero = mag_ff == '0;
   assign stat.both_even = !ga_ff[0] && !gb_ff[0];
   assign stat.a_even = !ga_ff[0];
   assign stat.gcd_done = gb_ff == '0;
   assign stat.div_busy = div_busy;

   assign res_num = num_ff;
   assign res_den = dn_ff;
   assign order = ord_ff;
   assign status = st_ff;
endmodule

// ----- hw/rtl/rau_sequencer.sv -----
// sequencer stepping the shared datapath through one item
module rau_sequencer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  rau_pkg::stat_type stat,
   output rau_pkg::ctrl_type ctrl
);
   rau_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rau_pkg::S_IDLE:     if (req_valid) state_in = rau_pkg::S_MUL1;
         rau_pkg::S_MUL1:     state_in = stat.in_err ? rau_pkg::S_DONE : rau_pkg::S_MUL2;
         rau_pkg::S_MUL2:     state_in = rau_pkg::S_SUM;
         rau_pkg::S_SUM:      state_in = stat.is_cmp ? rau_pkg::S_DONE : rau_pkg::S_GCD_INIT;
         rau_pkg::S_GCD_INIT: state_in = stat.mag_zero ? rau_pkg::S_DONE : rau_pkg::S_GCD_SH;
         rau_pkg::S_GCD_SH:   if (!stat.both_even) state_in = rau_pkg::S_GCD_A;
         rau_pkg::S_GCD_A:    if (!stat.a_even) state_in = rau_pkg::S_GCD_LOOP;
         rau_pkg::S_GCD_LOOP: if (stat.gcd_done) state_in = rau_pkg::S_DIV_NUM;
         rau_pkg::S_DIV_NUM:  if (!stat.div_busy) state_in = rau_pkg::S_DIV_DEN;
         rau_pkg::S_DIV_DEN:  if (!stat.div_busy) state_in = rau_pkg::S_CHECK;
         rau_pkg::S_CHECK:    state_in = rau_pkg::S_DONE;
         rau_pkg::S_DONE:     if (!rsp_stall) state_in = rau_pkg::S_IDLE;
         default:             state_in = rau_pkg::S_IDLE;
      endcase
   end

   logic div_started_ff;
   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         rau_pkg::S_IDLE:     ctrl.load = req_valid;
         rau_pkg::S_MUL1:     ctrl.mul1 = 1'b1;
         rau_pkg::S_MUL2:     ctrl.mul2 = 1'b1;
         rau_pkg::S_SUM:      ctrl.sum = 1'b1;
         rau_pkg::S_GCD_INIT: ctrl.gcd_init = !stat.mag_zero;
         rau_pkg::S_GCD_SH:   ctrl.gcd_sh = stat.both_even;
         rau_pkg::S_GCD_A:    ctrl.gcd_a = stat.a_even;
         rau_pkg::S_GCD_LOOP: begin
            ctrl.gcd_loop = !stat.gcd_done;
            ctrl.div_start_num = stat.gcd_done;
         end
         rau_pkg::S_DIV_NUM:  ctrl.div_start_den = !stat.div_busy;
         rau_pkg::S_CHECK:    ctrl.check = 1'b1;
         default:             ctrl = '0;
      endcase
   end

   // div_den wait: started the cycle before, busy rises next cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rau_pkg::S_IDLE;
         div_started_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         div_started_ff <= ctrl.div_start_num | ctrl.div_start_den;
      end
   end

   assign req_stall = state_ff != rau_pkg::S_IDLE;
   assign rsp_valid = state_ff == rau_pkg::S_DONE && !div_started_ff;
endmodule

// ----- hw/rtl/rational_arithmetic_unit.sv -----
// top level of the rational arithmetic unit
// Rational arithmetic on two fractions: add, subtract, multiply, divide and
// compare, one item at a time. A compare passes through the two multiply
// states and the sum state before the result beat is offered; a zero result
// also passes the gcd init state, and a zero denominator or divide by zero
// goes straight from the first multiply state to the result. Other items run
// the multiply and sum states, the binary gcd (one step per shift or
// subtract on the two 64-bit operands), two passes of the bit-serial divider
// and a check state; the gcd loop and the shared one-bit-a-cycle divider
// dominate the run time. req_stall stays high from acceptance until the
// result beat is taken. Unused modes behave as compare.
module rational_arithmetic_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_mode,
   input  logic signed [31:0] req_a_num,
   input  logic [30:0]        req_a_den,
   input  logic signed [31:0] req_b_num,
   input  logic [30:0]        req_b_den,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_res_num,
   output logic [30:0]        rsp_res_den,
   output logic [1:0]         rsp_order,
   output logic [1:0]         rsp_status
);
   rau_pkg::ctrl_type ctrl;
   rau_pkg::stat_type stat;

   // sequencer: one item in flight
   rau_sequencer u_seq (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .stat(stat), .ctrl(ctrl));

   // datapath: multiplier, gcd engine, divider, result registers
   rau_datapath u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .stat(stat),
      .req_mode(req_mode), .req_a_num(req_a_num), .req_a_den(req_a_den),
      .req_b_num(req_b_num), .req_b_den(req_b_den),
      .res_num(rsp_res_num), .res_den(rsp_res_den),
      .order(rsp_order), .status(rsp_status));

   // no new beat while a result is pending
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> req_stall)
      else $error("input taken while result pending");
   // error results are always 0/1
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != rau_pkg::ST_OK |-> rsp_res_num == 0 && rsp_res_den == 1)
      else $error("error result not zero over one");
   // result denominator is never zero
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> rsp_res_den != 0)
      else $error("zero result denominator");
endmodule

// ----- tb/testbench.sv -----
// testbench for the rational arithmetic unit: scoreboard, drivers and checks
`timescale 1ns / 1ps

typedef struct packed {
   logic signed [31:0] res_num;
   logic [30:0]        res_den;
   logic [1:0]         order;
   logic [1:0]         status;
} fraction_result_type;

class fraction_scoreboard;
   fraction_result_type pending[$];
   int unsigned         mismatches;

   // binary gcd over the wide magnitudes
   function automatic logic [63:0] gcd_of(logic [63:0] x, logic [63:0] y);
      int unsigned shift_count;
      logic [63:0] t;
      shift_count = 0;
      if (x == 0) return y;
      if (y == 0) return x;
      while (((x | y) & 64'd1) == 0) begin
         x = x >> 1;
         y = y >> 1;
         shift_count++;
      end
      while (x[0] == 1'b0) x = x >> 1;
      do begin
         while (y[0] == 1'b0) y = y >> 1;
         if (x > y) begin
            t = x;
            x = y;
            y = t;
         end
         y = y - x;
      end while (y != 0);
      return x << shift_count;
   endfunction

   function automatic fraction_result_type reduced(logic neg, logic [63:0] mag,
                                                   logic [63:0] den);
      fraction_result_type r;
      logic [63:0] g, lim;
      lim = 64'd1 << (rau_pkg::WordBits - 1);
      r = '{res_num: '0, res_den: 31'd1, order: rau_pkg::ORD_LT, status: rau_pkg::ST_OK};
      if (mag == 0) return r;
      g = gcd_of(mag, den);
      mag = mag / g;
      den = den / g;
      if (den > lim - 1 || (neg ? mag > lim : mag > lim - 1)) begin
         r.status = rau_pkg::ST_OVF;
         return r;
      end
      r.res_num = neg ? 32'(64'd0 - mag) : 32'(mag);
      r.res_den = 31'(den);
      return r;
   endfunction

   function automatic fraction_result_type compute(logic [2:0] mode,
         logic signed [31:0] an, logic [30:0] ad, logic signed [31:0] bn,
         logic [30:0] bd);
      fraction_result_type r;
      longint l, rr, s;
      logic [63:0] am, bm;
      r = '{res_num: '0, res_den: 31'd1, order: rau_pkg::ORD_LT, status: rau_pkg::ST_OK};
      am = an < 0 ? 64'(-longint'(an)) : 64'(an);
      bm = bn < 0 ? 64'(-longint'(bn)) : 64'(bn);
      if (ad == 0 || bd == 0) begin
         r.status = rau_pkg::ST_ZERO;
      end else if (mode == rau_pkg::MODE_ADD || mode == rau_pkg::MODE_SUB) begin
         l = longint'(an) * longint'({1'b0, bd});
         rr = (mode == rau_pkg::MODE_SUB ? -longint'(bn) : longint'(bn)) *
              longint'({1'b0, ad});
         s = l + rr;
         r = reduced(s < 0, s < 0 ? 64'(-s) : 64'(s), 64'(ad) * 64'(bd));
      end else if (mode == rau_pkg::MODE_MUL) begin
         r = reduced((an < 0) != (bn < 0), am * bm, 64'(ad) * 64'(bd));
      end else if (mode == rau_pkg::MODE_DIV) begin
         if (bn == 0) r.status = rau_pkg::ST_ZERO;
         else r = reduced((an < 0) != (bn < 0), am * 64'(bd), 64'(ad) * bm);
      end else begin
         l = longint'(an) * longint'({1'b0, bd});
         rr = longint'(bn) * longint'({1'b0, ad});
         r.order = l < rr ? rau_pkg::ORD_LT : (l == rr ? rau_pkg::ORD_EQ : rau_pkg::ORD_GT);
      end
      return r;
   endfunction

   function void note_request(logic [2:0] mode, logic signed [31:0] an,
         logic [30:0] ad, logic signed [31:0] bn, logic [30:0] bd);
      pending.push_back(compute(mode, an, ad, bn, bd));
   endfunction

   function void check_result(fraction_result_type got);
      fraction_result_type want;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result beat %p", got);
         return;
      end
      want = pending.pop_front();
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", want, got);
      end
   endfunction
endclass

module testbench;
   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [2:0]         req_mode;
   logic signed [31:0] req_a_num;
   logic [30:0]        req_a_den;
   logic signed [31:0] req_b_num;
   logic [30:0]        req_b_den;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_res_num;
   logic [30:0]        rsp_res_den;
   logic [1:0]         rsp_order;
   logic [1:0]         rsp_status;

   fraction_scoreboard fractions;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned quiet_cycles;
   bit          timed_out;

   localparam int unsigned QuietLimit = 20000;

   rational_arithmetic_unit u_top (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side: random stall, checking on each accepted beat
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         fractions.check_result('{rsp_res_num, rsp_res_den, rsp_order, rsp_status});
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // watchdog: cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit && !timed_out) begin
         timed_out = 1'b1;
         $display("Test completed with failures");
         $finish;
      end
   end

   // one request beat, with an optional idle gap beforehand
   task automatic send_request(logic [2:0] mode, logic signed [31:0] an,
                               logic [30:0] ad, logic signed [31:0] bn,
                               logic [30:0] bd);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_a_num <= an;
      req_a_den <= ad;
      req_b_num <= bn;
      req_b_den <= bd;
      do @(posedge clock); while (req_stall);
      fractions.note_request(mode, an, ad, bn, bd);
   endtask

   // numerators: mostly small, sometimes full range or extremes
   function automatic logic signed [31:0] pick_num();
      case ($urandom_range(9))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2, 3: return $urandom;
         default: return $signed($urandom_range(2000)) - 1000;
      endcase
   endfunction

   function automatic logic [30:0] pick_den();
      case ($urandom_range(19))
         0: return 31'd0;
         1: return 31'h7fff_ffff;
         2, 3, 4: return 31'($urandom);
         default: return 31'($urandom_range(999, 1));
      endcase
   endfunction

   task automatic random_requests(int unsigned count);
      repeat (count)
         send_request(3'($urandom_range(7)), pick_num(), pick_den(), pick_num(),
                      pick_den());
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (fractions.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      fractions = new();
      timed_out = 1'b0;
      send_idle_pct = 7;
      recv_idle_pct = 57;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = rau_pkg::MODE_ADD;
      req_a_num = '0;
      req_a_den = 31'd1;
      req_b_num = '0;
      req_b_den = 31'd1;
      rsp_stall = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: every mode, extremes, zero denominators, divide by zero
      send_request(rau_pkg::MODE_ADD, 32'sd1, 31'd2, 32'sd1, 31'd3);
      send_request(rau_pkg::MODE_SUB, 32'sd1, 31'd2, 32'sd1, 31'd2);
      send_request(rau_pkg::MODE_MUL, -32'sd3, 31'd4, 32'sd8, 31'd9);
      send_request(rau_pkg::MODE_DIV, 32'sd3, 31'd4, -32'sd3, 31'd8);
      send_request(rau_pkg::MODE_CMP, 32'sd1, 31'd3, 32'sd2, 31'd6);
      send_request(rau_pkg::MODE_CMP, -32'sd1, 31'd3, 32'sd2, 31'd6);
      send_request(rau_pkg::MODE_CMP, 32'sd5, 31'd3, 32'sd2, 31'd6);
      send_request(rau_pkg::MODE_ADD, 32'sd1, 31'd0, 32'sd1, 31'd1);
      send_request(rau_pkg::MODE_MUL, 32'sd1, 31'd1, 32'sd1, 31'd0);
      send_request(rau_pkg::MODE_DIV, 32'sd7, 31'd3, 32'sd0, 31'd5);
      send_request(rau_pkg::MODE_ADD, 32'sh7fff_ffff, 31'd1, 32'sh7fff_ffff, 31'd1);
      send_request(rau_pkg::MODE_SUB, 32'sh8000_0000, 31'd1, 32'sd0, 31'd1);
      send_request(rau_pkg::MODE_MUL, 32'sh8000_0000, 31'd1, -32'sd1, 31'd1);
      send_request(rau_pkg::MODE_MUL, 32'sh8000_0000, 31'd1, 32'sd1, 31'd1);
      send_request(rau_pkg::MODE_DIV, 32'sd1, 31'h7fff_ffff, 32'sd1, 31'h7fff_ffff);
      send_request(rau_pkg::MODE_MUL, 32'sd1, 31'h7fff_ffff, 32'sd1, 31'h7fff_ffff);
      send_request(rau_pkg::MODE_ADD, 32'sh8000_0000, 31'h7fff_ffff, 32'sh7fff_ffff,
                   31'h7fff_ffff);
      send_request(3'd5, 32'sd1, 31'd2, 32'sd1, 31'd3);
      send_request(3'd7, 32'sh7fff_ffff, 31'd1, 32'sh8000_0000, 31'd1);
      send_request(rau_pkg::MODE_SUB, 32'sd4, 31'd6, 32'sd2, 31'd3);
      send_request(rau_pkg::MODE_ADD, 32'sd0, 31'd5, 32'sd0, 31'd7);

      // pause until everything is back
      drain();

      random_requests(350);
      send_idle_pct = 57;
      recv_idle_pct = 7;
      random_requests(350);
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_requests(330);

      drain();
      repeat (250) @(posedge clock);
      if (fractions.mismatches == 0 && fractions.pending.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule

// ----- sim.f -----
hw/rtl/rau_pkg.sv
hw/rtl/rau_divider.sv
hw/rtl/rau_datapath.sv
hw/rtl/rau_sequencer.sv
hw/rtl/rational_arithmetic_unit.sv
tb/testbench.sv
